>>> hw/rtl/alloc_trk_pkg.sv
// Shared constants, codes and types of the allocation tracker.
`timescale 1ns / 1ps

package alloc_trk_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int CMD_W = 2;
	localparam int PTR_W = 64;
	localparam int SIZE_W = 32;
	localparam int STAMP_W = 63;
	localparam int STATUS_W = 3;
	localparam int CNT_W = 32;
	localparam int BYTES_W = 48;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

	localparam logic [STATUS_W-1:0] ST_ALLOC_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREE_HIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREE_MISS = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

	// Classified request handed from the table stage to the statistics stage.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SIZE_W-1:0]   size;
		logic [STAMP_W-1:0]  stamp;
	} evt_t;

	typedef struct packed {
		logic [CNT_W-1:0]   alloc_total;
		logic [CNT_W-1:0]   free_total;
		logic [BYTES_W-1:0] alloc_bytes_total;
		logic [BYTES_W-1:0] free_bytes_total;
		logic [CNT_W-1:0]   outstanding_count;
		logic [BYTES_W-1:0] outstanding_bytes;
		logic [CNT_W-1:0]   peak_count;
		logic [STAMP_W-1:0] peak_count_time;
		logic [BYTES_W-1:0] peak_bytes;
		logic [STAMP_W-1:0] peak_bytes_time;
	} stats_t;

endpackage

>>> hw/rtl/alloc_trk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module alloc_trk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/alloc_trk_table.sv
// Pointer table: parallel key match, lowest free slot, slot update and size store.
`timescale 1ns / 1ps

module alloc_trk_table import alloc_trk_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd_en,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [PTR_W-1:0]    ptr,
	input  logic [SIZE_W-1:0]   alloc_size,
	output logic [STATUS_W-1:0] status,
	output logic [SIZE_W-1:0]   stored_size
);

	logic [TABLE_ENTRIES-1:0] slot_valid_q;
	logic [PTR_W-1:0]         slot_pointer_q [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] match;
	logic                     hit;
	logic                     empty_any;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         empty_idx;
	logic                     do_alloc;
	logic                     do_free;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = slot_valid_q[i] && (slot_pointer_q[i] == ptr);
		end
	end

	assign hit = |match;
	assign empty_any = ~&slot_valid_q;

	// Priority encode from the top down so the lowest index wins.
	always_comb begin
		hit_idx = '0;
		empty_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!slot_valid_q[i]) begin
				empty_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		case (cmd)
			CMD_ALLOC: begin
				if (hit) begin
					status = ST_DUPLICATE;
				end else if (!empty_any) begin
					status = ST_FULL;
				end else begin
					status = ST_ALLOC_OK;
				end
			end
			CMD_FREE: status = hit ? ST_FREE_HIT : ST_FREE_MISS;
			default:  status = ST_CLEARED;
		endcase
	end

	assign do_alloc = upd_en && (cmd == CMD_ALLOC) && !hit && empty_any;
	assign do_free = upd_en && (cmd == CMD_FREE) && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else begin
			if (do_alloc) begin
				slot_valid_q[empty_idx] <= 1'b1;
			end
			if (do_free) begin
				slot_valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc) begin
			slot_pointer_q[empty_idx] <= ptr;
		end
	end

	// Sizes are read on every table update, at the matched slot; only a matched free uses the data.
	alloc_trk_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (TABLE_ENTRIES)
	) u_size_ram (
		.clk   (clk),
		.we    (do_alloc),
		.waddr (empty_idx),
		.wdata (alloc_size),
		.re    (upd_en),
		.raddr (hit_idx),
		.rdata (stored_size)
	);

endmodule

>>> hw/rtl/alloc_trk_stats.sv
// Running totals, outstanding values and peak tracking.
`timescale 1ns / 1ps

module alloc_trk_stats import alloc_trk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  evt_t              evt,
	input  logic [SIZE_W-1:0] freed_size,
	output stats_t            stats
);

	stats_t             stats_q;
	stats_t             stats_d;
	logic [CNT_W-1:0]   out_cnt_inc;
	logic [BYTES_W-1:0] out_bytes_inc;
	logic [BYTES_W-1:0] size_ext;
	logic [BYTES_W-1:0] freed_ext;

	assign size_ext = BYTES_W'(evt.size);
	assign freed_ext = BYTES_W'(freed_size);
	assign out_cnt_inc = stats_q.outstanding_count + CNT_W'(1);
	assign out_bytes_inc = stats_q.outstanding_bytes + size_ext;

	always_comb begin
		stats_d = stats_q;
		case (evt.status)
			ST_ALLOC_OK: begin
				stats_d.alloc_total = stats_q.alloc_total + CNT_W'(1);
				stats_d.alloc_bytes_total = stats_q.alloc_bytes_total + size_ext;
				stats_d.outstanding_count = out_cnt_inc;
				stats_d.outstanding_bytes = out_bytes_inc;
				if (out_cnt_inc > stats_q.peak_count) begin
					stats_d.peak_count = out_cnt_inc;
					stats_d.peak_count_time = evt.stamp;
				end
				if (out_bytes_inc > stats_q.peak_bytes) begin
					stats_d.peak_bytes = out_bytes_inc;
					stats_d.peak_bytes_time = evt.stamp;
				end
			end
			ST_FREE_HIT: begin
				stats_d.free_total = stats_q.free_total + CNT_W'(1);
				stats_d.free_bytes_total = stats_q.free_bytes_total + freed_ext;
				stats_d.outstanding_count = stats_q.outstanding_count - CNT_W'(1);
				stats_d.outstanding_bytes = stats_q.outstanding_bytes - freed_ext;
			end
			ST_CLEARED: stats_d = '0;
			default:    stats_d = stats_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= '0;
		end else if (en) begin
			stats_q <= stats_d;
		end
	end

	assign stats = stats_q;

endmodule

>>> hw/rtl/allocation_tracker_with_peaks.sv
// Top level of the allocation tracker: stream ports, pipeline control, result register.
`timescale 1ns / 1ps

// Tracks heap allocate and free requests in a table of TABLE_ENTRIES pointers
// and keeps running totals with peak outstanding count and bytes. Each request
// on the slave stream (s_tuser = command: 0 allocate, 1 free, 2 clear
// statistics; command 3 is taken and dropped without a result) gives exactly
// one result on the master stream, with m_tuser = status and the statistics as
// they stand after that request. A new request is taken every cycle unless the
// master side stalls; each one passes a three-register path (input stage,
// table stage, result register), and m_tvalid for its result comes from
// the result register. The table stage does a full parallel pointer compare
// and picks the lowest free slot combinationally; stored sizes sit in a RAM
// whose registered read feeds the statistics stage. The table starts empty
// after reset with no clearing pass. Backpressure on the master side stalls
// a stage only when the stage after it is full and stalled, so bubbles are
// squeezed out.
module allocation_tracker_with_peaks import alloc_trk_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// [63:0] ptr, [95:64] alloc_size, [158:96] timestamp, [159] zero
	input  logic [159:0]  s_tdata,
	// [1:0] cmd
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// [31:0] freed_size, [63:32] alloc_total, [95:64] free_total,
	// [143:96] alloc_bytes_total, [191:144] free_bytes_total,
	// [223:192] outstanding_count, [271:224] outstanding_bytes,
	// [303:272] peak_count, [366:304] peak_count_time, [414:367] peak_bytes,
	// [477:415] peak_bytes_time, [479:478] zero
	output logic [479:0]  m_tdata,
	// [2:0] status
	output logic [2:0]    m_tuser
);

	// Input stage
	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [PTR_W-1:0]    ptr_s1;
	logic [SIZE_W-1:0]   size_s1;
	logic [STAMP_W-1:0]  stamp_s1;

	// Table stage
	logic                valid_s2;
	evt_t                evt_s2;

	// Result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SIZE_W-1:0]   freed_q;

	logic                out_ready;
	logic                s2_ready;
	logic                s1_ready;
	logic                s_accept;
	logic                fire1;
	logic                fire2;
	logic [STATUS_W-1:0] tbl_status;
	logic [SIZE_W-1:0]   stored_size;
	logic [SIZE_W-1:0]   freed_size;
	stats_t              stats;

	// Each stage moves when the one ahead of it is empty or moving.
	assign out_ready = !out_valid_q || m_tready;
	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s_tready = s1_ready;
	assign s_accept = s_tvalid && s1_ready;
	assign fire1 = valid_s1 && s2_ready;
	assign fire2 = valid_s2 && out_ready;

	// Hold the request; drop the unused command code here so it never
	// reaches the table or produces a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_tvalid && (s_tuser != CMD_RSVD);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1 <= s_tuser;
			ptr_s1 <= s_tdata[63:0];
			size_s1 <= s_tdata[95:64];
			stamp_s1 <= s_tdata[158:96];
		end
	end

	// Table lookup and update happen as the request leaves the input stage.
	alloc_trk_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd_en      (fire1),
		.cmd         (cmd_s1),
		.ptr         (ptr_s1),
		.alloc_size  (size_s1),
		.status      (tbl_status),
		.stored_size (stored_size)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			evt_s2.status <= tbl_status;
			evt_s2.size <= size_s1;
			evt_s2.stamp <= stamp_s1;
		end
	end

	// The RAM read data is only meaningful for a matched free.
	assign freed_size = (evt_s2.status == ST_FREE_HIT) ? stored_size : '0;

	// Statistics advance only when a result is loaded, so they always match
	// the result currently presented on the master side.
	alloc_trk_stats u_stats (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (fire2),
		.evt        (evt_s2),
		.freed_size (freed_size),
		.stats      (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			status_q <= evt_s2.status;
			freed_q <= freed_size;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = status_q;
	assign m_tdata = {
		2'b00,
		stats.peak_bytes_time,
		stats.peak_bytes,
		stats.peak_count_time,
		stats.peak_count,
		stats.outstanding_bytes,
		stats.outstanding_count,
		stats.free_bytes_total,
		stats.alloc_bytes_total,
		stats.free_total,
		stats.alloc_total,
		freed_q
	};

	// A size is only reported for a matched free.
	a_freed_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_FREE_HIT)) |-> (freed_q == '0))
		else $error("freed size reported without a matched free");

	// A clear result shows the checked statistics fields at zero.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_CLEARED)) |->
		((stats.alloc_total == '0) && (stats.peak_count == '0) &&
		(stats.outstanding_bytes == '0) && (stats.peak_bytes_time == '0)))
		else $error("statistics not cleared");

	// Right after a recorded allocate the peaks cover the outstanding values.
	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_ALLOC_OK)) |->
		((stats.peak_count >= stats.outstanding_count) &&
		(stats.peak_bytes >= stats.outstanding_bytes)))
		else $error("peak below outstanding after allocate");

endmodule
